// ===== rtl/script_token_lexer_macros.svh =====
// Assertion macros shared by the lexer's checker.
// Depends on: nothing; users provide clk and rst in scope.
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define STL_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define STL_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/stl_pkg.sv =====
// Shared constants, token kinds and character helpers for the script lexer.
// Depends on: nothing.
package stl_pkg;

  // Parameter defaults
  localparam int POSITION_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF   = 8;

  // Fixed field widths
  localparam int KIND_BITS  = 4;
  localparam int VALUE_BITS = 32;
  localparam int CHAR_BITS  = 8;

  // Result queue depth (power of two, at least 2)
  localparam int QUEUE_DEPTH = 4;

  // Token kinds
  localparam logic [KIND_BITS-1:0] KIND_WORD   = 4'd0;
  localparam logic [KIND_BITS-1:0] KIND_SCOPED = 4'd1;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN = 4'd2;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN = 4'd3;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE = 4'd4;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE = 4'd5;
  localparam logic [KIND_BITS-1:0] KIND_COMMA  = 4'd6;
  localparam logic [KIND_BITS-1:0] KIND_EQUALS = 4'd7;
  localparam logic [KIND_BITS-1:0] KIND_CONST  = 4'd8;
  localparam logic [KIND_BITS-1:0] KIND_END    = 4'd9;
  localparam logic [KIND_BITS-1:0] KIND_UNREC  = 4'd10;

  // Character codes
  localparam logic [CHAR_BITS-1:0] CHAR_NUL        = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_TAB        = 8'h09;
  localparam logic [CHAR_BITS-1:0] CHAR_LF         = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CHAR_CR         = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_LPAREN     = 8'h28;
  localparam logic [CHAR_BITS-1:0] CHAR_RPAREN     = 8'h29;
  localparam logic [CHAR_BITS-1:0] CHAR_COMMA      = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS      = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_DOT        = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CHAR_SLASH      = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO       = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE       = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_EQUALS     = 8'h3D;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CHAR_LBRACE     = 8'h7B;
  localparam logic [CHAR_BITS-1:0] CHAR_RBRACE     = 8'h7D;

  // Numeric constants
  localparam logic [VALUE_BITS-1:0] TENTH_Q32 = 32'h1999999A;
  localparam logic [VALUE_BITS-1:0] MAG_CAP   = 32'h80000000;
  localparam logic [VALUE_BITS-1:0] POS_LIMIT = 32'h7FFFFFFF;

  function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [KIND_BITS-1:0] symbol_kind(input logic [CHAR_BITS-1:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      CHAR_LPAREN: k = KIND_LPAREN;
      CHAR_RPAREN: k = KIND_RPAREN;
      CHAR_LBRACE: k = KIND_LBRACE;
      CHAR_RBRACE: k = KIND_RBRACE;
      CHAR_COMMA:  k = KIND_COMMA;
      CHAR_EQUALS: k = KIND_EQUALS;
      default:     k = KIND_UNREC;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/stl_core.sv =====
// Lexer state and per-character next-state logic; yields up to two tokens per step.
// Depends on: stl_pkg.
module stl_core #(
  parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
  parameter int FRACTION_BITS = stl_pkg::FRACTION_BITS_DEF,
  parameter int LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF,
  parameter int RES_BITS      = stl_pkg::KIND_BITS + stl_pkg::VALUE_BITS
                                + POSITION_BITS + LENGTH_BITS + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [stl_pkg::CHAR_BITS-1:0]  character,
  output logic [1:0]                     push_count,
  output logic [RES_BITS-1:0]            push_data0,
  output logic [RES_BITS-1:0]            push_data1
);

  typedef enum logic [9:0] {
    MODE_IDLE    = 10'b0000000001,
    MODE_WORD    = 10'b0000000010,
    MODE_UNDER   = 10'b0000000100,
    MODE_SCOPED  = 10'b0000001000,
    MODE_MINUS   = 10'b0000010000,
    MODE_INT     = 10'b0000100000,
    MODE_DOT     = 10'b0001000000,
    MODE_FRAC    = 10'b0010000000,
    MODE_SLASH   = 10'b0100000000,
    MODE_COMMENT = 10'b1000000000
  } mode_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [35:0] FRAC_ROUND = 36'd1 << (31 - FRACTION_BITS);

  mode_t                     mode, mode_next;
  logic [31:0]               mag, mag_next;
  logic [31:0]               weight, weight_next;
  logic                      neg, neg_next;
  logic [POSITION_BITS-1:0]  begin_pos, begin_pos_next;
  logic [LENGTH_BITS-1:0]    len, len_next;
  logic [POSITION_BITS-1:0]  pos, pos_next;

  logic                      letter, digit, alnum, blank, line_end;
  logic [3:0]                dval;
  logic [LENGTH_BITS-1:0]    len_grown;
  logic [31:0]               int_base, int_mag, frac_mag, frac_weight, const_value;
  logic                      emit1, emit2, fresh, ended;
  logic [stl_pkg::KIND_BITS-1:0]  kind1, kind2;
  logic [stl_pkg::VALUE_BITS-1:0] value1;
  logic [LENGTH_BITS-1:0]    len1, len2;
  logic [RES_BITS-1:0]       res1, res2;

  // mag*10 + d*2^F, capped at 2^31
  function automatic logic [31:0] int_step(input logic [31:0] base, input logic [3:0] dig);
    logic [35:0] sum;
    sum = ({4'b0, base} << 3) + ({4'b0, base} << 1) + (36'(dig) << FRACTION_BITS);
    return (sum > 36'(stl_pkg::MAG_CAP)) ? stl_pkg::MAG_CAP : sum[31:0];
  endfunction

  assign letter   = stl_pkg::is_letter(character);
  assign digit    = stl_pkg::is_digit(character);
  assign alnum    = letter || digit;
  assign line_end = (character == stl_pkg::CHAR_CR) || (character == stl_pkg::CHAR_LF);
  assign blank    = (character == stl_pkg::CHAR_SPACE) || (character == stl_pkg::CHAR_TAB) ||
                    line_end;
  assign dval     = 4'(character - stl_pkg::CHAR_ZERO);
  assign len_grown = (len != LEN_MAX) ? len + 1'b1 : len;

  // A fresh digit starts from zero magnitude
  assign int_base = (mode == MODE_INT || mode == MODE_MINUS) ? mag : 32'd0;
  assign int_mag  = int_step(int_base, dval);

  // Fraction digit: (d*w + round) >> (32-F), then next weight = w/10 rounded
  always_comb begin
    logic [35:0] term;
    logic [35:0] msum;
    logic [63:0] wprod;
    term  = ((36'(dval) * {4'b0, weight}) + FRAC_ROUND) >> (32 - FRACTION_BITS);
    msum  = {4'b0, mag} + term;
    frac_mag = (msum > 36'(stl_pkg::MAG_CAP)) ? stl_pkg::MAG_CAP : msum[31:0];
    wprod = ({32'b0, weight} * {32'b0, stl_pkg::TENTH_Q32}) + 64'h0000_0000_8000_0000;
    frac_weight = wprod[63:32];
  end

  always_comb begin
    if (neg) begin
      const_value = mag[31] ? stl_pkg::MAG_CAP : (~mag + 32'd1);
    end else begin
      const_value = mag[31] ? stl_pkg::POS_LIMIT : mag;
    end
  end

  always_comb begin
    mode_next      = mode;
    mag_next       = mag;
    weight_next    = weight;
    neg_next       = neg;
    begin_pos_next = begin_pos;
    len_next       = len;
    pos_next       = (pos != POS_MAX) ? pos + 1'b1 : pos;
    emit1  = 1'b0;
    kind1  = stl_pkg::KIND_UNREC;
    value1 = '0;
    len1   = len;
    emit2  = 1'b0;
    kind2  = stl_pkg::KIND_END;
    len2   = '0;
    fresh  = 1'b0;
    ended  = 1'b0;

    case (mode)
      MODE_WORD: begin
        if (alnum) begin
          len_next = len_grown;
        end else if (character == stl_pkg::CHAR_UNDERSCORE) begin
          len_next  = len_grown;
          mode_next = MODE_UNDER;
        end else begin
          emit1 = 1'b1;
          kind1 = stl_pkg::KIND_WORD;
          fresh = 1'b1;
        end
      end
      MODE_UNDER: begin
        if (letter) begin
          len_next  = len_grown;
          mode_next = MODE_SCOPED;
        end else begin
          emit1 = 1'b1;
          fresh = 1'b1;
        end
      end
      MODE_SCOPED: begin
        if (alnum) begin
          len_next = len_grown;
        end else begin
          emit1 = 1'b1;
          kind1 = stl_pkg::KIND_SCOPED;
          fresh = 1'b1;
        end
      end
      MODE_MINUS: begin
        if (digit) begin
          len_next  = len_grown;
          mag_next  = int_mag;
          mode_next = MODE_INT;
        end else begin
          emit1 = 1'b1;
          fresh = 1'b1;
        end
      end
      MODE_INT: begin
        if (digit) begin
          len_next = len_grown;
          mag_next = int_mag;
        end else if (character == stl_pkg::CHAR_DOT) begin
          len_next  = len_grown;
          mode_next = MODE_DOT;
        end else begin
          emit1  = 1'b1;
          kind1  = stl_pkg::KIND_CONST;
          value1 = const_value;
          fresh  = 1'b1;
        end
      end
      MODE_DOT: begin
        if (digit) begin
          len_next    = len_grown;
          mag_next    = frac_mag;
          weight_next = frac_weight;
          mode_next   = MODE_FRAC;
        end else begin
          emit1 = 1'b1;
          fresh = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (digit) begin
          len_next    = len_grown;
          mag_next    = frac_mag;
          weight_next = frac_weight;
        end else if (character == stl_pkg::CHAR_DOT) begin
          // second dot: number so far is bad, dot lexed again
          emit1 = 1'b1;
          fresh = 1'b1;
        end else begin
          emit1  = 1'b1;
          kind1  = stl_pkg::KIND_CONST;
          value1 = const_value;
          fresh  = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (character == stl_pkg::CHAR_SLASH) begin
          mode_next = MODE_COMMENT;
        end else begin
          emit1 = 1'b1;
          len1  = LENGTH_BITS'(1);
          fresh = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (character == stl_pkg::CHAR_NUL) begin
          emit2 = 1'b1;
          ended = 1'b1;
        end else if (line_end) begin
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      mode_next = MODE_IDLE;
      if (character == stl_pkg::CHAR_NUL) begin
        emit2 = 1'b1;
        ended = 1'b1;
      end else if (blank) begin
        mode_next = MODE_IDLE;
      end else if (character == stl_pkg::CHAR_SLASH || letter ||
                   character == stl_pkg::CHAR_MINUS || digit) begin
        begin_pos_next = pos;
        len_next       = LENGTH_BITS'(1);
        mag_next       = '0;
        weight_next    = stl_pkg::TENTH_Q32;
        neg_next       = 1'b0;
        if (character == stl_pkg::CHAR_SLASH) begin
          mode_next = MODE_SLASH;
        end else if (letter) begin
          mode_next = MODE_WORD;
        end else if (digit) begin
          mode_next = MODE_INT;
          mag_next  = int_mag;
        end else begin
          mode_next = MODE_MINUS;
          neg_next  = 1'b1;
        end
      end else begin
        emit2 = 1'b1;
        kind2 = stl_pkg::symbol_kind(character);
        len2  = LENGTH_BITS'(1);
      end
    end

    if (ended) begin
      mode_next      = MODE_IDLE;
      mag_next       = '0;
      weight_next    = stl_pkg::TENTH_Q32;
      neg_next       = 1'b0;
      begin_pos_next = '0;
      len_next       = '0;
      pos_next       = '0;
    end
  end

  // Pack: kind, value, start, length, last
  assign res1 = {kind1, value1, begin_pos, len1, ~emit2};
  assign res2 = {kind2, {stl_pkg::VALUE_BITS{1'b0}}, pos, len2, 1'b1};

  always_comb begin
    push_count = '0;
    push_data0 = emit1 ? res1 : res2;
    push_data1 = res2;
    if (step) begin
      push_count = {1'b0, emit1} + {1'b0, emit2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      mag       <= '0;
      weight    <= stl_pkg::TENTH_Q32;
      neg       <= 1'b0;
      begin_pos <= '0;
      len       <= '0;
      pos       <= '0;
    end else if (step) begin
      mode      <= mode_next;
      mag       <= mag_next;
      weight    <= weight_next;
      neg       <= neg_next;
      begin_pos <= begin_pos_next;
      len       <= len_next;
      pos       <= pos_next;
    end
  end

endmodule

// ===== rtl/stl_queue.sv =====
// Small result queue: takes zero, one or two tokens per cycle, gives at most one.
// Depends on: stl_pkg.
module stl_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  logic [WIDTH-1:0] push_data0,
  input  logic [WIDTH-1:0] push_data1,
  output logic             room,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH  = stl_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign pop_data  = slots[head];
  // Room for a two-token step regardless of this cycle's pop
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign count_next = count + CNT_W'(push_count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[tail] <= push_data0;
    end
    if (push_count == 2'd2) begin
      slots[tail + PTR_W'(1)] <= push_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_W'(pop);
      tail  <= tail + PTR_W'(push_count);
      count <= count_next;
    end
  end

endmodule

// ===== rtl/script_token_lexer.sv =====
// Script token lexer, top level. Depends on stl_pkg, stl_core, stl_queue.
//
// Streaming lexer taking one script byte per character transaction and giving
// one token per token transaction. Whitespace, CR/LF and // comments are skipped;
// words, scoped words, the symbols ( ) { } , = and decimal constants (signed
// Q(32-F).F, saturated) come out with start offset and saturating length. A
// zero byte gives an end token and returns the lexer to its reset state.
// Throughput: one character per cycle while each character yields at most one
// token and the token sink keeps up. A character that closes a token and is
// itself a symbol or the terminator yields two tokens; the result queue drains
// at most one token per cycle, so a run of such characters holds off the
// character channel. An accepted character waits in the input register until
// the queue has room, then the lexer logic lexes it into the result queue.
// last_of_run marks the final token produced by one character.
module script_token_lexer #(
  parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
  parameter int FRACTION_BITS = stl_pkg::FRACTION_BITS_DEF,
  parameter int LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // character channel
  input  logic                              char_valid,
  output logic                              char_ready,
  input  logic [stl_pkg::CHAR_BITS-1:0]     character,
  // token channel
  output logic                              token_valid,
  input  logic                              token_ready,
  output logic [stl_pkg::KIND_BITS-1:0]     token_kind,
  output logic signed [stl_pkg::VALUE_BITS-1:0] number_value,
  output logic [POSITION_BITS-1:0]          start_offset,
  output logic [LENGTH_BITS-1:0]            token_length,
  output logic                              last_of_run
);

  localparam int RES_BITS = stl_pkg::KIND_BITS + stl_pkg::VALUE_BITS
                            + POSITION_BITS + LENGTH_BITS + 1;

  // Input register: holds one accepted character until the queue can take
  // the (up to two) tokens it may produce.
  logic [stl_pkg::CHAR_BITS-1:0] held_char;
  logic                          held_valid;
  logic                          room;
  logic                          step;

  logic [1:0]          push_count;
  logic [RES_BITS-1:0] push_data0, push_data1;
  logic [RES_BITS-1:0] head_data;

  // Lex the held character once the queue has space for two tokens.
  assign step       = held_valid && room;
  // Accept while the register is empty or being emptied this cycle.
  assign char_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (char_ready) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      held_char <= character;
    end
  end

  stl_core #(
    .POSITION_BITS (POSITION_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .RES_BITS      (RES_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .character  (held_char),
    .push_count (push_count),
    .push_data0 (push_data0),
    .push_data1 (push_data1)
  );

  stl_queue #(
    .WIDTH (RES_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_data0 (push_data0),
    .push_data1 (push_data1),
    .room       (room),
    .pop_valid  (token_valid),
    .pop_ready  (token_ready),
    .pop_data   (head_data)
  );

  // Unpack the queue head: kind, value, start, length, last.
  assign {token_kind, number_value, start_offset, token_length, last_of_run} = head_data;

endmodule

// ===== rtl/stl_checker.sv =====
// Port-level checks on the token channel of the script lexer, bound to the top.
// Depends on: stl_pkg, script_token_lexer_macros.svh.
`include "script_token_lexer_macros.svh"

module stl_checker #(
  parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  token_valid,
  input logic                                  token_ready,
  input logic [stl_pkg::KIND_BITS-1:0]         token_kind,
  input logic signed [stl_pkg::VALUE_BITS-1:0] number_value,
  input logic [POSITION_BITS-1:0]              start_offset,
  input logic [LENGTH_BITS-1:0]                token_length,
  input logic                                  last_of_run
);

  // Stalled token holds
  `STL_ASSERT_NEXT(a_token_hold, token_valid && !token_ready, token_valid && $stable(token_kind) && $stable(number_value) && $stable(start_offset) && $stable(token_length) && $stable(last_of_run), "token changed under stall")

  // End token: empty, zero value, closes its run
  `STL_ASSERT_NOW(a_end_shape, token_valid && token_kind == stl_pkg::KIND_END, token_length == '0 && number_value == '0 && last_of_run, "malformed end token")

  // Only constants carry a value
  `STL_ASSERT_NOW(a_value_zero, token_valid && token_kind != stl_pkg::KIND_CONST, number_value == '0, "value on non-constant")

  // Symbols are one character long
  `STL_ASSERT_NOW(a_symbol_len, token_valid && token_kind >= stl_pkg::KIND_LPAREN && token_kind <= stl_pkg::KIND_EQUALS, token_length == LENGTH_BITS'(1), "symbol length not 1")

endmodule

bind script_token_lexer stl_checker #(
  .POSITION_BITS (POSITION_BITS),
  .LENGTH_BITS   (LENGTH_BITS)
) u_stl_checker (.*);

// ===== tb/tb_script_token_lexer.sv =====
// Self-checking testbench for script_token_lexer: random and directed character streams.
// Depends on stl_pkg and the script_token_lexer RTL; tokens are checked against an
// in-bench shadow of the lexer held in a small scoreboard class.
module tb_script_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths follow the DUT's default parameters.
  typedef logic [stl_pkg::POSITION_BITS_DEF-1:0] pos_t;
  typedef logic [stl_pkg::LENGTH_BITS_DEF-1:0]   len_t;
  typedef logic [stl_pkg::CHAR_BITS-1:0]         char_t;

  localparam int FRAC_W      = stl_pkg::FRACTION_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on either channel

  // Lexer modes of the shadow model.
  typedef enum logic [3:0] {
    LX_IDLE, LX_WORD, LX_UNDER, LX_SCOPED, LX_MINUS,
    LX_INT, LX_DOT, LX_FRAC, LX_SLASH, LX_COMMENT
  } lex_mode_t;

  typedef struct packed {
    logic [stl_pkg::KIND_BITS-1:0]  kind;
    logic [stl_pkg::VALUE_BITS-1:0] value;
    pos_t                           start;
    len_t                           length;
    logic                           last;
  } token_t;

  // Shadow lexer plus the queue of tokens it has predicted but the DUT has not yet given.
  class token_tracker;
    lex_mode_t   mode;
    logic [63:0] magnitude;   // unsigned magnitude, Q.F, capped at 2^31
    logic [63:0] weight;      // weight of the next fraction digit, Q0.32
    bit          negative;
    pos_t        tok_start;
    len_t        tok_len;
    pos_t        position;
    token_t      pending_tokens[$];
    int          errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      mode      = LX_IDLE;
      magnitude = 64'd0;
      weight    = {32'd0, stl_pkg::TENTH_Q32};
      negative  = 1'b0;
      tok_start = '0;
      tok_len   = '0;
      position  = '0;
    endfunction

    function bit alpha_char(char_t c);
      return (c >= stl_pkg::CHAR_UPPER_A && c <= stl_pkg::CHAR_UPPER_Z) ||
             (c >= stl_pkg::CHAR_LOWER_A && c <= stl_pkg::CHAR_LOWER_Z);
    endfunction

    function bit num_char(char_t c);
      return c >= stl_pkg::CHAR_ZERO && c <= stl_pkg::CHAR_NINE;
    endfunction

    function void emit(logic [stl_pkg::KIND_BITS-1:0] kind,
                       logic [stl_pkg::VALUE_BITS-1:0] value,
                       pos_t start, len_t length);
      token_t t;
      t.kind   = kind;
      t.value  = value;
      t.start  = start;
      t.length = length;
      t.last   = 1'b0;
      pending_tokens.push_back(t);
    endfunction

    function void open_token(lex_mode_t m, pos_t at);
      mode      = m;
      tok_start = at;
      tok_len   = len_t'(1);
      magnitude = 64'd0;
      weight    = {32'd0, stl_pkg::TENTH_Q32};
      negative  = 1'b0;
    endfunction

    function void grow();
      if (tok_len != '1) tok_len++;
    endfunction

    function void add_int(logic [3:0] d);
      logic [63:0] m;
      m = magnitude * 10 + (64'(d) << FRAC_W);
      magnitude = (m > {32'd0, stl_pkg::MAG_CAP}) ? {32'd0, stl_pkg::MAG_CAP} : m;
    endfunction

    function void add_frac(logic [3:0] d);
      logic [63:0] c;
      logic [63:0] m;
      c = (64'(d) * weight + (64'd1 << (31 - FRAC_W))) >> (32 - FRAC_W);
      m = magnitude + c;
      magnitude = (m > {32'd0, stl_pkg::MAG_CAP}) ? {32'd0, stl_pkg::MAG_CAP} : m;
      weight = (weight * {32'd0, stl_pkg::TENTH_Q32} + 64'h8000_0000) >> 32;
    endfunction

    // Signed Q16.16 of the open constant; a full-scale magnitude pins to the rails.
    function logic [stl_pkg::VALUE_BITS-1:0] value_now();
      if (negative)
        return (magnitude >= {32'd0, stl_pkg::MAG_CAP}) ? stl_pkg::MAG_CAP :
               (~magnitude[31:0] + 32'd1);
      return (magnitude >= {32'd0, stl_pkg::MAG_CAP}) ? stl_pkg::POS_LIMIT :
             magnitude[31:0];
    endfunction

    // One accepted character transaction: close/extend the open token, lex afresh if needed.
    function void note_char(char_t c);
      int   queued;
      pos_t here;
      bit   fresh;
      bit   ended;
      bit   alnum;
      logic [stl_pkg::KIND_BITS-1:0] sym;
      queued = pending_tokens.size();
      here   = position;
      fresh  = 1'b0;
      ended  = 1'b0;
      alnum  = alpha_char(c) || num_char(c);
      case (mode)
        LX_WORD: begin
          if (alnum) grow();
          else if (c == stl_pkg::CHAR_UNDERSCORE) begin
            grow();
            mode = LX_UNDER;
          end else begin
            emit(stl_pkg::KIND_WORD, '0, tok_start, tok_len);
            fresh = 1'b1;
          end
        end
        LX_UNDER: begin
          if (alpha_char(c)) begin
            grow();
            mode = LX_SCOPED;
          end else begin
            emit(stl_pkg::KIND_UNREC, '0, tok_start, tok_len);
            fresh = 1'b1;
          end
        end
        LX_SCOPED: begin
          if (alnum) grow();
          else begin
            emit(stl_pkg::KIND_SCOPED, '0, tok_start, tok_len);
            fresh = 1'b1;
          end
        end
        LX_MINUS: begin
          if (num_char(c)) begin
            grow();
            add_int(c[3:0]);
            mode = LX_INT;
          end else begin
            emit(stl_pkg::KIND_UNREC, '0, tok_start, tok_len);
            fresh = 1'b1;
          end
        end
        LX_INT: begin
          if (num_char(c)) begin
            grow();
            add_int(c[3:0]);
          end else if (c == stl_pkg::CHAR_DOT) begin
            grow();
            mode = LX_DOT;
          end else begin
            emit(stl_pkg::KIND_CONST, value_now(), tok_start, tok_len);
            fresh = 1'b1;
          end
        end
        LX_DOT: begin
          if (num_char(c)) begin
            grow();
            add_frac(c[3:0]);
            mode = LX_FRAC;
          end else begin
            emit(stl_pkg::KIND_UNREC, '0, tok_start, tok_len);
            fresh = 1'b1;
          end
        end
        LX_FRAC: begin
          if (num_char(c)) begin
            grow();
            add_frac(c[3:0]);
          end else if (c == stl_pkg::CHAR_DOT) begin
            emit(stl_pkg::KIND_UNREC, '0, tok_start, tok_len);
            fresh = 1'b1;
          end else begin
            emit(stl_pkg::KIND_CONST, value_now(), tok_start, tok_len);
            fresh = 1'b1;
          end
        end
        LX_SLASH: begin
          if (c == stl_pkg::CHAR_SLASH) mode = LX_COMMENT;
          else begin
            emit(stl_pkg::KIND_UNREC, '0, tok_start, len_t'(1));
            fresh = 1'b1;
          end
        end
        LX_COMMENT: begin
          if (c == stl_pkg::CHAR_NUL) begin
            emit(stl_pkg::KIND_END, '0, here, '0);
            ended = 1'b1;
          end else if (c == stl_pkg::CHAR_CR || c == stl_pkg::CHAR_LF) mode = LX_IDLE;
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        mode = LX_IDLE;
        if (c == stl_pkg::CHAR_NUL) begin
          emit(stl_pkg::KIND_END, '0, here, '0);
          ended = 1'b1;
        end else if (c == stl_pkg::CHAR_SPACE || c == stl_pkg::CHAR_TAB ||
                     c == stl_pkg::CHAR_CR || c == stl_pkg::CHAR_LF) begin
        end else if (c == stl_pkg::CHAR_SLASH) open_token(LX_SLASH, here);
        else if (alpha_char(c)) open_token(LX_WORD, here);
        else if (c == stl_pkg::CHAR_MINUS) begin
          open_token(LX_MINUS, here);
          negative = 1'b1;
        end else if (num_char(c)) begin
          open_token(LX_INT, here);
          add_int(c[3:0]);
        end else begin
          case (c)
            stl_pkg::CHAR_LPAREN: sym = stl_pkg::KIND_LPAREN;
            stl_pkg::CHAR_RPAREN: sym = stl_pkg::KIND_RPAREN;
            stl_pkg::CHAR_LBRACE: sym = stl_pkg::KIND_LBRACE;
            stl_pkg::CHAR_RBRACE: sym = stl_pkg::KIND_RBRACE;
            stl_pkg::CHAR_COMMA:  sym = stl_pkg::KIND_COMMA;
            stl_pkg::CHAR_EQUALS: sym = stl_pkg::KIND_EQUALS;
            default:              sym = stl_pkg::KIND_UNREC;
          endcase
          emit(sym, '0, here, len_t'(1));
        end
      end

      if (ended) restart();
      else if (position != '1) position++;

      if (pending_tokens.size() > queued)
        pending_tokens[pending_tokens.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // One accepted token transaction against the oldest prediction.
    function void check_token(token_t got);
      token_t want;
      if (pending_tokens.size() == 0) begin
        errors++;
        $display("%0t: token with none expected, actual kind %0d start %0d length %0d",
                 $time, got.kind, got.start, got.length);
        return;
      end
      want = pending_tokens.pop_front();
      compare_field("token_kind",   32'(want.kind),   32'(got.kind));
      compare_field("number_value", want.value,       got.value);
      compare_field("start_offset", 32'(want.start),  32'(got.start));
      compare_field("token_length", 32'(want.length), 32'(got.length));
      compare_field("last_of_run",  32'(want.last),   32'(got.last));
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  char_valid = 1'b0;
  logic  char_ready;
  char_t character = '0;
  logic  token_valid;
  logic  token_ready = 1'b0;
  logic [stl_pkg::KIND_BITS-1:0]         token_kind;
  logic signed [stl_pkg::VALUE_BITS-1:0] number_value;
  pos_t                                  start_offset;
  len_t                                  token_length;
  logic                                  last_of_run;

  token_tracker tracker;
  int send_idle_pct = 0;    // chance per cycle that the sender holds off
  int stall_pct     = 0;    // chance per cycle that the token sink stalls
  int chars_sent    = 0;
  int quiet_cycles  = 0;

  script_token_lexer DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .character    (character),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .number_value (number_value),
    .start_offset (start_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  always #2 clk = ~clk;

  // Token sink: check every token transaction, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst) begin
      token_ready <= 1'b0;
    end else begin
      if (token_valid && token_ready)
        tracker.check_token('{token_kind, number_value, start_offset, token_length,
                              last_of_run});
      token_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (token_valid && token_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_script_token_lexer: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Character transaction. Valid is only dropped while idling before the next
  // character, so it is never lowered and raised within one time step.
  task automatic send_char(input char_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    character  <= c;
    do @(posedge clk); while (!char_ready);
    tracker.note_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(char_t'(s[i]));
  endtask

  function automatic char_t any_letter();
    int n;
    n = $urandom_range(0, 51);
    return (n < 26) ? char_t'(stl_pkg::CHAR_UPPER_A + n) :
                      char_t'(stl_pkg::CHAR_LOWER_A + n - 26);
  endfunction

  function automatic char_t any_digit();
    return char_t'(stl_pkg::CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic char_t any_blank();
    case ($urandom_range(0, 3))
      0:       return stl_pkg::CHAR_SPACE;
      1:       return stl_pkg::CHAR_TAB;
      2:       return stl_pkg::CHAR_CR;
      default: return stl_pkg::CHAR_LF;
    endcase
  endfunction

  // One random chunk of script. Mostly well-formed tokens with random content,
  // the rest broken tokens and raw noise. Terminators only when allowed.
  task automatic send_piece(input bit allow_end);
    int    pick;
    int    n;
    char_t b;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      // word, now and then long enough to saturate the length, maybe scoped
      n = ($urandom_range(0, 119) == 0) ? $urandom_range(256, 270) : $urandom_range(1, 6);
      send_char(any_letter());
      repeat (n - 1) send_char(($urandom_range(0, 3) == 0) ? any_digit() : any_letter());
      if ($urandom_range(0, 2) == 0) begin
        send_char(stl_pkg::CHAR_UNDERSCORE);
        if ($urandom_range(0, 4) != 0) begin
          send_char(any_letter());
          repeat ($urandom_range(0, 4))
            send_char(($urandom_range(0, 2) == 0) ? any_digit() : any_letter());
        end
      end
    end else if (pick < 42) begin
      // constant: optional minus, long digit runs saturate the magnitude
      if ($urandom_range(0, 3) == 0) send_char(stl_pkg::CHAR_MINUS);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 4);
      repeat (n) send_char(any_digit());
      if ($urandom_range(0, 1) == 1) begin
        send_char(stl_pkg::CHAR_DOT);
        repeat ($urandom_range(0, 7)) send_char(any_digit());
        if ($urandom_range(0, 9) == 0) send_char(stl_pkg::CHAR_DOT);
      end
    end else if (pick < 58) begin
      case ($urandom_range(0, 5))
        0:       send_char(stl_pkg::CHAR_LPAREN);
        1:       send_char(stl_pkg::CHAR_RPAREN);
        2:       send_char(stl_pkg::CHAR_LBRACE);
        3:       send_char(stl_pkg::CHAR_RBRACE);
        4:       send_char(stl_pkg::CHAR_COMMA);
        default: send_char(stl_pkg::CHAR_EQUALS);
      endcase
    end else if (pick < 70) begin
      send_char(any_blank());
    end else if (pick < 76) begin
      // comment with arbitrary body bytes, closed by a line end or a terminator
      send_char(stl_pkg::CHAR_SLASH);
      send_char(stl_pkg::CHAR_SLASH);
      repeat ($urandom_range(0, 6)) begin
        b = char_t'($urandom_range(1, 255));
        send_char((b == stl_pkg::CHAR_CR || b == stl_pkg::CHAR_LF) ?
                  stl_pkg::CHAR_SPACE : b);
      end
      if (allow_end && $urandom_range(0, 4) == 0) send_char(stl_pkg::CHAR_NUL);
      else send_char(($urandom_range(0, 1) == 1) ? stl_pkg::CHAR_CR : stl_pkg::CHAR_LF);
    end else if (pick < 84) begin
      case ($urandom_range(0, 3))
        0:       send_char(stl_pkg::CHAR_MINUS);
        1:       send_char(stl_pkg::CHAR_SLASH);
        2:       send_char(stl_pkg::CHAR_UNDERSCORE);
        default: send_char(stl_pkg::CHAR_DOT);
      endcase
    end else if (pick < 95) begin
      send_char(char_t'($urandom_range(1, 255)));
    end else begin
      send_char(allow_end ? stl_pkg::CHAR_NUL : stl_pkg::CHAR_SPACE);
    end
    if ($urandom_range(0, 1) == 1) send_char(any_blank());
  endtask

  initial begin
    int goal;
    int phase;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: scoped word, symbols, negative fraction, bad underscore, trailing
    // dot, bare minus, lone slash, byte 0xFF, second dot, terminator in a comment,
    // terminator right after a constant.
    send_text("a_b1=-2.5,(x_){9.}- /");
    send_char(8'hFF);
    send_text("1.2.3//c");
    send_char(stl_pkg::CHAR_NUL);
    send_text("7");
    send_char(stl_pkg::CHAR_NUL);

    // Random streams under four flow-control mixes.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      goal = chars_sent + 354;
      while (chars_sent < goal) send_piece(1'b1);
      send_char(stl_pkg::CHAR_NUL);
    end

    char_valid <= 1'b0;
    while (tracker.pending_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_tokens.size() == 0)
      $display("tb_script_token_lexer: PASS");
    else
      $display("tb_script_token_lexer: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/stl_pkg.sv
rtl/stl_core.sv
rtl/stl_queue.sv
rtl/script_token_lexer.sv
rtl/stl_checker.sv
tb/tb_script_token_lexer.sv
